>>> design/tfmb_pkg.sv
package tfmb_pkg;

  // Default geometry
  localparam int DEF_MAX_WIDTH  = 640;
  localparam int DEF_MAX_HEIGHT = 480;

  // Field widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int PIX_W      = 8;
  localparam int COL_OUT_W  = 10;
  localparam int ROW_OUT_W  = 9;
  localparam int HITS_OUT_W = 17;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_MARGIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_GROW       = 3'd5;

  // Reset values
  localparam logic [9:0] RST_FRAME_WIDTH    = 10'd640;
  localparam logic [8:0] RST_FRAME_HEIGHT   = 9'd480;
  localparam logic [7:0] RST_DIFF_THRESHOLD = 8'd35;
  localparam logic [5:0] RST_BORDER_MARGIN  = 6'd10;
  localparam logic [7:0] RST_SPREAD_LIMIT   = 8'd20;
  localparam logic [5:0] RST_BOX_GROW       = 6'd10;

  // Grey weights, Q14
  localparam logic [21:0] GREY_WA  = 22'd4899;
  localparam logic [21:0] GREY_WB  = 22'd9617;
  localparam logic [21:0] GREY_WC  = 22'd1868;
  localparam logic [21:0] GREY_RND = 22'd8192;

  // Per-pixel event from the pixel stage to the frame statistics
  typedef struct packed {
    logic valid;
    logic clear;  // frame_start seen on this pixel
    logic last;   // last pixel of the frame
    logic ero;    // eroded mark
    logic samp;   // inside margin on an even step
  } tfmb_ev_t;

endpackage

>>> design/tfmb_pix_if.sv
interface tfmb_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan_a;
  logic [7:0] chan_b;
  logic [7:0] chan_c;
  logic       frame_start;

  modport source(output valid, chan_a, chan_b, chan_c, frame_start, input ready);
  modport sink(input valid, chan_a, chan_b, chan_c, frame_start, output ready);
endinterface

>>> design/tfmb_res_if.sv
interface tfmb_res_if;
  logic        valid;
  logic        ready;
  logic        motion_found;
  logic [9:0]  box_left;
  logic [8:0]  box_top;
  logic [9:0]  box_right;
  logic [8:0]  box_bottom;
  logic [16:0] hit_count;

  modport source(output valid, motion_found, box_left, box_top, box_right, box_bottom,
                 hit_count, input ready);
  modport sink(input valid, motion_found, box_left, box_top, box_right, box_bottom,
               hit_count, output ready);
endinterface

>>> design/tfmb_pixel.sv
module tfmb_pixel #(
  parameter int MAX_WIDTH  = 640,
  parameter int MAX_HEIGHT = 480
) (
  input  logic                              clk,
  input  logic                              rst,
  tfmb_pix_if.sink                          pix,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    eff_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]   eff_h,
  input  logic [7:0]                        diff_threshold,
  input  logic [5:0]                        border_margin,
  input  logic                              hold,
  output tfmb_pkg::tfmb_ev_t                ev,
  output logic [$clog2(MAX_WIDTH)-1:0]      ev_col,
  output logic [$clog2(MAX_HEIGHT)-1:0]     ev_row
);
  import tfmb_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic {ST_IDLE, ST_UPD} st_t;

  logic [15:0] fstore [DEPTH];
  logic        mline [MAX_WIDTH];

  st_t          st;
  logic [CW-1:0] col, p_col, col_use;
  logic [RW-1:0] row, p_row, row_use;
  logic [AW-1:0] base, p_base, base_use, p_addr;
  logic          left, p_left, p_clear;
  logic [7:0]    g;
  logic [15:0]   fs_q;
  logic          ml_q;
  logic          accept;
  logic [21:0]   grey_sum;
  logic [7:0]    f1, f2, d01, d12;
  logic          mark, vert, ero, col_end, row_end, samp_c, samp_r;

  assign pix.ready = (st == ST_IDLE) && !hold;
  assign accept    = pix.valid && pix.ready;

  assign col_use  = pix.frame_start ? '0 : col;
  assign row_use  = pix.frame_start ? '0 : row;
  assign base_use = pix.frame_start ? '0 : base;
  assign grey_sum = 22'(pix.chan_a) * GREY_WA + 22'(pix.chan_b) * GREY_WB
                  + 22'(pix.chan_c) * GREY_WC + GREY_RND;

  // store read, registered on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      fs_q <= fstore[base_use + AW'(col_use)];
      ml_q <= mline[col_use];
    end
  end

  // write back
  always_ff @(posedge clk) begin
    if (st == ST_UPD) begin
      fstore[p_addr] <= {f1, g};
      mline[p_col]   <= mark;
    end
  end

  always_comb begin
    f1      = fs_q[7:0];
    f2      = fs_q[15:8];
    d01     = (g > f1) ? g - f1 : f1 - g;
    d12     = (f1 > f2) ? f1 - f2 : f2 - f1;
    mark    = (d01 & d12) > diff_threshold;
    vert    = mark & ((p_row == '0) | ml_q);
    ero     = vert & p_left;
    col_end = int'(p_col) + 1 >= int'(eff_w);
    row_end = int'(p_row) + 1 >= int'(eff_h);
    samp_c  = int'(p_col) >= int'(border_margin)
           && int'(p_col) + int'(border_margin) < int'(eff_w)
           && (p_col[0] == border_margin[0]);
    samp_r  = int'(p_row) >= int'(border_margin)
           && int'(p_row) + int'(border_margin) < int'(eff_h)
           && (p_row[0] == border_margin[0]);
  end

  always_comb begin
    ev.valid = (st == ST_UPD);
    ev.clear = p_clear;
    ev.last  = col_end && row_end;
    ev.ero   = ero;
    ev.samp  = samp_c && samp_r;
  end
  assign ev_col = p_col;
  assign ev_row = p_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= ST_IDLE;
      col  <= '0;
      row  <= '0;
      base <= '0;
      left <= 1'b1;
    end else begin
      unique case (st)
        ST_IDLE: begin
          if (accept) begin
            st      <= ST_UPD;
            p_col   <= col_use;
            p_row   <= row_use;
            p_base  <= base_use;
            p_addr  <= base_use + AW'(col_use);
            p_left  <= pix.frame_start ? 1'b1 : left;
            p_clear <= pix.frame_start;
            g       <= grey_sum[21:14];
          end
        end
        ST_UPD: begin
          st <= ST_IDLE;
          if (col_end) begin
            col  <= '0;
            left <= 1'b1;
            if (row_end) begin
              row  <= '0;
              base <= '0;
            end else begin
              row  <= p_row + 1'b1;
              base <= p_base + AW'(MAX_WIDTH);
            end
          end else begin
            col  <= p_col + 1'b1;
            row  <= p_row;
            base <= p_base;
            left <= vert;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> design/tfmb_stats.sv
module tfmb_stats #(
  parameter int MAX_WIDTH  = 640,
  parameter int MAX_HEIGHT = 480
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tfmb_pkg::tfmb_ev_t                ev,
  input  logic [$clog2(MAX_WIDTH)-1:0]      ev_col,
  input  logic [$clog2(MAX_HEIGHT)-1:0]     ev_row,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    eff_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]   eff_h,
  input  logic [7:0]                        spread_limit,
  input  logic [5:0]                        box_grow,
  output logic                              busy,
  tfmb_res_if.source                        res
);
  import tfmb_pkg::*;

  localparam int WW   = $clog2(MAX_WIDTH+1);
  localparam int HW   = $clog2(MAX_HEIGHT+1);
  localparam int NW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int LTW  = NW + 8;
  localparam int CMPW = 2 * NW + 16;
  localparam int RST_W = (int'(RST_FRAME_WIDTH) > MAX_WIDTH) ? MAX_WIDTH
                                                              : int'(RST_FRAME_WIDTH);
  localparam int RST_H = (int'(RST_FRAME_HEIGHT) > MAX_HEIGHT) ? MAX_HEIGHT
                                                                : int'(RST_FRAME_HEIGHT);

  typedef enum logic [2:0] {S_IDLE, S_TOT, S_LT, S_SQ, S_SCL, S_CMP, S_OUT} st_t;

  st_t           st;
  logic [1:0]    fseen;
  logic [NW-1:0] ones, hits, b_ones, b_hits, a_ones, a_hits;
  logic [WW-1:0] minc, maxc, b_minc, b_maxc, a_minc, a_maxc;
  logic [HW-1:0] minr, maxr, b_minr, b_maxr, a_minr, a_maxr;

  // end of frame snapshot and math
  logic [NW-1:0]   s_n, s_hits, tot, dif;
  logic [WW-1:0]   s_minc, s_maxc, s_w;
  logic [HW-1:0]   s_minr, s_maxr, s_h;
  logic [7:0]      s_lim;
  logic [5:0]      s_grow;
  logic [LTW-1:0]  lt;
  logic [2*NW-1:0] lhsx;
  logic [CMPW-1:0] rhs, lhs;
  logic            mot;
  logic [NW-1:0]   hv;
  logic [WW-1:0]   box_l, box_r;
  logic [HW-1:0]   box_t, box_b;

  assign busy = (st != S_IDLE);

  always_comb begin
    b_ones = ev.clear ? '0 : ones;
    b_hits = ev.clear ? '0 : hits;
    b_minc = ev.clear ? eff_w : minc;
    b_maxc = ev.clear ? '0 : maxc;
    b_minr = ev.clear ? eff_h : minr;
    b_maxr = ev.clear ? '0 : maxr;
    a_ones = b_ones + NW'(ev.ero);
    a_hits = b_hits;
    a_minc = b_minc;
    a_maxc = b_maxc;
    a_minr = b_minr;
    a_maxr = b_maxr;
    if (ev.ero && ev.samp) begin
      a_hits = b_hits + 1'b1;
      if (WW'(ev_col) < b_minc) a_minc = WW'(ev_col);
      if (WW'(ev_col) > b_maxc) a_maxc = WW'(ev_col);
      if (HW'(ev_row) < b_minr) a_minr = HW'(ev_row);
      if (HW'(ev_row) > b_maxr) a_maxr = HW'(ev_row);
    end
  end

  // spread test and box growth
  always_comb begin
    hv  = (lhs < rhs) ? s_hits : '0;
    mot = (hv != '0);
    box_l = '0;
    box_r = '0;
    box_t = '0;
    box_b = '0;
    if (mot) begin
      box_l = (int'(s_minc) > int'(s_grow)) ? s_minc - WW'(s_grow) : s_minc;
      box_t = (int'(s_minr) > int'(s_grow)) ? s_minr - HW'(s_grow) : s_minr;
      box_r = (int'(s_maxc) + int'(s_grow) + 1 < int'(s_w)) ? s_maxc + WW'(s_grow)
                                                             : s_maxc;
      box_b = (int'(s_maxr) + int'(s_grow) + 1 < int'(s_h)) ? s_maxr + HW'(s_grow)
                                                             : s_maxr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      fseen     <= '0;
      ones      <= '0;
      hits      <= '0;
      minc      <= WW'(RST_W);
      maxc      <= '0;
      minr      <= HW'(RST_H);
      maxr      <= '0;
      res.valid <= 1'b0;
    end else begin
      // S_OUT reloads the result register itself
      if (res.valid && res.ready && st != S_OUT) res.valid <= 1'b0;

      if (ev.valid) begin
        if (ev.last) begin
          ones <= '0;
          hits <= '0;
          minc <= eff_w;
          maxc <= '0;
          minr <= eff_h;
          maxr <= '0;
          if (fseen >= 2'd2) begin
            s_n    <= a_ones;
            s_hits <= a_hits;
            s_minc <= a_minc;
            s_maxc <= a_maxc;
            s_minr <= a_minr;
            s_maxr <= a_maxr;
            s_w    <= eff_w;
            s_h    <= eff_h;
            s_lim  <= spread_limit;
            s_grow <= box_grow;
            st     <= S_TOT;
          end else begin
            fseen <= fseen + 1'b1;
          end
        end else begin
          ones <= a_ones;
          hits <= a_hits;
          minc <= a_minc;
          maxc <= a_maxc;
          minr <= a_minr;
          maxr <= a_maxr;
        end
      end

      unique case (st)
        S_IDLE: ;
        S_TOT: begin
          tot <= NW'(NW'(s_w) * NW'(s_h));
          st  <= S_LT;
        end
        S_LT: begin
          lt  <= LTW'(s_lim) * LTW'(tot);
          dif <= tot - s_n;
          st  <= S_SQ;
        end
        S_SQ: begin
          rhs  <= CMPW'(lt) * CMPW'(lt);
          lhsx <= (2*NW)'(dif) * (2*NW)'(s_n);
          st   <= S_SCL;
        end
        S_SCL: begin
          // 65025 = 2^16 - 2^9 + 1
          lhs <= (CMPW'(lhsx) << 16) - (CMPW'(lhsx) << 9) + CMPW'(lhsx);
          st  <= S_CMP;
        end
        S_CMP: st <= S_OUT;
        S_OUT: begin
          if (!res.valid || res.ready) begin
            res.valid        <= 1'b1;
            res.motion_found <= mot;
            res.box_left     <= COL_OUT_W'(box_l);
            res.box_top      <= ROW_OUT_W'(box_t);
            res.box_right    <= COL_OUT_W'(box_r);
            res.box_bottom   <= ROW_OUT_W'(box_b);
            res.hit_count    <= HITS_OUT_W'(hv);
            st               <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/three_frame_motion_box_core.sv
// Three-frame difference motion detector, one result per frame from the third on.
// Input: one pixel beat in flight at a time; the frame store is read on the
//   accept cycle and written back on the next (single-port read-modify-write).
// Result: after the last pixel beat the spread test multiplies run in S_TOT,
//   S_LT, S_SQ, S_SCL, then S_CMP and S_OUT; input stalls until S_OUT is left.
// Reset (rst, synchronous): registers to defaults, position and counts cleared;
//   frame store and line mask are not cleared and need two frames to fill.
module three_frame_motion_box_core #(
  parameter int MAX_WIDTH  = tfmb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tfmb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tfmb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tfmb_pkg::CFG_DATA_W-1:0]    cfg_data,
  tfmb_pix_if.sink                           pix,
  tfmb_res_if.source                         res
);
  import tfmb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int HW = $clog2(MAX_HEIGHT+1);

  // Configuration registers
  logic [9:0] frame_width;
  logic [8:0] frame_height;
  logic [7:0] diff_threshold;
  logic [5:0] border_margin;
  logic [7:0] spread_limit;
  logic [5:0] box_grow;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= RST_FRAME_WIDTH;
      frame_height   <= RST_FRAME_HEIGHT;
      diff_threshold <= RST_DIFF_THRESHOLD;
      border_margin  <= RST_BORDER_MARGIN;
      spread_limit   <= RST_SPREAD_LIMIT;
      box_grow       <= RST_BOX_GROW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:    frame_width    <= cfg_data[9:0];
        REG_FRAME_HEIGHT:   frame_height   <= cfg_data[8:0];
        REG_DIFF_THRESHOLD: diff_threshold <= cfg_data[7:0];
        REG_BORDER_MARGIN:  border_margin  <= cfg_data[5:0];
        REG_SPREAD_LIMIT:   spread_limit   <= cfg_data[7:0];
        REG_BOX_GROW:       box_grow       <= cfg_data[5:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // Working frame size: zero reads as one, anything above the store clamps.
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  always_comb begin
    if (frame_width == '0)                    eff_w = WW'(1);
    else if (int'(frame_width) > MAX_WIDTH)   eff_w = WW'(MAX_WIDTH);
    else                                      eff_w = WW'(frame_width);
    if (frame_height == '0)                   eff_h = HW'(1);
    else if (int'(frame_height) > MAX_HEIGHT) eff_h = HW'(MAX_HEIGHT);
    else                                      eff_h = HW'(frame_height);
  end

  tfmb_ev_t      ev;
  logic [CW-1:0] ev_col;
  logic [RW-1:0] ev_row;
  logic          busy;

  // Pixel path: grey, store read-modify-write, mark and 2x2 erosion.
  tfmb_pixel #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_pixel (
    .clk           (clk),
    .rst           (rst),
    .pix           (pix),
    .eff_w         (eff_w),
    .eff_h         (eff_h),
    .diff_threshold(diff_threshold),
    .border_margin (border_margin),
    .hold          (busy),
    .ev            (ev),
    .ev_col        (ev_col),
    .ev_row        (ev_row)
  );

  // Frame statistics, spread test and result register.
  tfmb_stats #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_stats (
    .clk         (clk),
    .rst         (rst),
    .ev          (ev),
    .ev_col      (ev_col),
    .ev_row      (ev_row),
    .eff_w       (eff_w),
    .eff_h       (eff_h),
    .spread_limit(spread_limit),
    .box_grow    (box_grow),
    .busy        (busy),
    .res         (res)
  );

endmodule

>>> design/tfmb_checker.sv
module tfmb_props (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        motion_found,
  input logic [9:0]  box_left,
  input logic [8:0]  box_top,
  input logic [9:0]  box_right,
  input logic [8:0]  box_bottom,
  input logic [16:0] hit_count
);

  // one pixel in flight: a beat is followed by a busy cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a pixel beat");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(hit_count)))
    else $error("stalled result changed");

  a_no_motion_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !motion_found) |->
      (box_left == 10'd0 && box_right == 10'd0 && box_top == 9'd0 &&
       box_bottom == 9'd0 && hit_count == 17'd0))
    else $error("box or count set without motion");

  a_motion_box: assert property (@(posedge clk) disable iff (rst)
    (out_valid && motion_found) |->
      (hit_count != 17'd0 && box_left <= box_right && box_top <= box_bottom))
    else $error("inconsistent motion box");

endmodule

bind three_frame_motion_box_core tfmb_props u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (pix.valid),
  .in_ready    (pix.ready),
  .out_valid   (res.valid),
  .out_ready   (res.ready),
  .motion_found(res.motion_found),
  .box_left    (res.box_left),
  .box_top     (res.box_top),
  .box_right   (res.box_right),
  .box_bottom  (res.box_bottom),
  .hit_count   (res.hit_count)
);
